// File: rtl/scsa_pkg.sv
`timescale 1ns / 1ps

package scsa_pkg;

   // Fixed field widths of the result and configuration words.
   localparam int GAIN_W      = 24;
   localparam int VALUE_W     = 34;
   localparam int CSR_DATA_W  = 34;
   localparam int CSR_INDEX_W = 2;
   localparam int CLAMP_W     = 2;

   // The average is kept with 16 fraction bits; gain carries 20.
   localparam int FRAC_BITS   = 16;
   localparam int SCALE_SHIFT = 20;

   localparam logic [GAIN_W-1:0]         GAIN_RESET       = 24'd51763;
   localparam logic signed [VALUE_W-1:0] OFFSET_RESET     = 34'sd0;
   localparam logic signed [VALUE_W-1:0] CLAMP_LOW_RESET  = 34'sd0;
   localparam logic signed [VALUE_W-1:0] CLAMP_HIGH_RESET = 34'sd3309568;

   localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
   localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd1;
   localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN       = 2'd0,
      CSR_OFFSET     = 2'd1,
      CSR_CLAMP_LOW  = 2'd2,
      CSR_CLAMP_HIGH = 2'd3
   } scsa_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BOUND_MUL,
      ST_BOUND_SUB,
      ST_READ,
      ST_DIFF,
      ST_SQUARE,
      ST_TEST,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SCALE,
      ST_OFFSET,
      ST_OUTPUT
   } scsa_state_type;

   typedef struct packed {
      logic take_sample;
      logic bound_mul;
      logic bound_sub;
      logic mem_read;
      logic diff;
      logic square;
      logic test;
      logic div_start;
      logic scale;
      logic offset_add;
      logic load_out;
   } scsa_cmd_type;

   typedef struct packed {
      logic pass_done;
      logic div_done;
      logic out_free;
   } scsa_status_type;

endpackage

// File: rtl/scsa_div.sv
`timescale 1ns / 1ps

module scsa_div import scsa_pkg::*; #(
   parameter int NUM_W = 31,
   parameter int DEN_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // Restoring division, one quotient bit per cycle. The numerator shifts out
   // of the top of quot_ff while quotient bits shift in at the bottom.
   assign trial = {rem_ff, quot_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, denom};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quot_in = numer;
         rem_in  = '0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[NUM_W-2:0], fits};
         rem_in  = fits ? DEN_W'(trial - {1'b0, denom}) : trial[DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// File: rtl/scsa_datapath.sv
`timescale 1ns / 1ps

module scsa_datapath import scsa_pkg::*; #(
   parameter int MAX_SAMPLES = 16,
   parameter int ADC_BITS    = 10,
   parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic [ADC_BITS-1:0]    req_sample,
   input  scsa_cmd_type           cmd,
   output scsa_status_type        status,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [VALUE_W-1:0]     rsp_value,
   output logic [CNT_W-1:0]       rsp_kept_count,
   output logic [CLAMP_W-1:0]     rsp_clamp_hit,
   output logic                   rsp_dropped
);

   localparam int IDX_W  = $clog2(MAX_SAMPLES);
   localparam int SUM_W  = ADC_BITS + CNT_W;
   localparam int SQS_W  = 2 * ADC_BITS + CNT_W;
   localparam int NQ_W   = SQS_W + CNT_W;
   localparam int BND_W  = NQ_W + 4;
   localparam int DIF_W  = SUM_W + 1;
   localparam int SQ_W   = 2 * SUM_W;
   localparam int NUM_W  = SUM_W + FRAC_BITS;
   localparam int AVG_W  = ADC_BITS + FRAC_BITS;
   localparam int PROD_W = AVG_W + GAIN_W;
   localparam int SCL_W  = PROD_W + 1 - SCALE_SHIFT;
   localparam int VAL_W  = ((AVG_W + 6 > VALUE_W) ? AVG_W + 6 : VALUE_W) + 1;
   localparam logic [PROD_W:0] ROUND_ADD = (PROD_W + 1)'(1) << (SCALE_SHIFT - 1);

   // Configuration registers.
   logic [GAIN_W-1:0]         gain_ff;
   logic signed [VALUE_W-1:0] offset_ff;
   logic signed [VALUE_W-1:0] clamp_low_ff;
   logic signed [VALUE_W-1:0] clamp_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= GAIN_RESET;
         offset_ff     <= OFFSET_RESET;
         clamp_low_ff  <= CLAMP_LOW_RESET;
         clamp_high_ff <= CLAMP_HIGH_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_GAIN:       gain_ff       <= csr_data[GAIN_W-1:0];
            CSR_OFFSET:     offset_ff     <= csr_data[VALUE_W-1:0];
            CSR_CLAMP_LOW:  clamp_low_ff  <= csr_data[VALUE_W-1:0];
            CSR_CLAMP_HIGH: clamp_high_ff <= csr_data[VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   // Burst accumulation.
   logic [ADC_BITS-1:0]   store_mem [MAX_SAMPLES];
   logic [CNT_W-1:0]      count_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [SQS_W-1:0]      sq_sum_ff;
   logic                  overflow_ff;
   logic                  store_full;
   logic [2*ADC_BITS-1:0] sample_sq;

   assign store_full = count_ff >= CNT_W'(MAX_SAMPLES);
   assign sample_sq  = (2*ADC_BITS)'(req_sample) * (2*ADC_BITS)'(req_sample);

   always_ff @(posedge clock) begin
      if (reset || cmd.load_out) begin
         count_ff    <= '0;
         sum_ff      <= '0;
         sq_sum_ff   <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.take_sample) begin
         if (store_full) begin
            overflow_ff <= 1'b1;
         end else begin
            count_ff  <= count_ff + 1'b1;
            sum_ff    <= sum_ff + SUM_W'(req_sample);
            sq_sum_ff <= sq_sum_ff + SQS_W'(sample_sq);
         end
      end
   end

   logic [IDX_W-1:0]    idx_ff;
   logic [CNT_W-1:0]    pass_idx_ff;
   logic [ADC_BITS-1:0] rd_data_ff;

   assign idx_ff = pass_idx_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.take_sample && !store_full) begin
         store_mem[count_ff[IDX_W-1:0]] <= req_sample;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= store_mem[idx_ff];
      end
   end

   // Bound 9*(n*Q - S^2), built in the bound_mul and then the bound_sub step.
   logic [NQ_W-1:0]  nq_ff, nq_in;
   logic [NQ_W-1:0]  ss_ff, ss_in;
   logic [NQ_W-1:0]  spread;
   logic [BND_W-1:0] bound_ff;

   assign nq_in  = NQ_W'(count_ff) * NQ_W'(sq_sum_ff);
   assign ss_in  = NQ_W'(sum_ff) * NQ_W'(sum_ff);
   assign spread = nq_ff - ss_ff;

   // Second pass: each stored word goes through read, difference, square and test in turn.
   logic [SUM_W-1:0]              nv;
   logic signed [DIF_W-1:0]       diff_ff, diff_in;
   logic signed [2*DIF_W-1:0]     diff_sq;
   logic [SQ_W-1:0]               sq_ff;
   logic [CNT_W-1:0]              kept_ff;
   logic [SUM_W-1:0]              kept_sum_ff;
   logic                          in_band;

   assign nv      = SUM_W'(count_ff) * SUM_W'(rd_data_ff);
   assign diff_in = $signed({1'b0, nv}) - $signed({1'b0, sum_ff});
   assign diff_sq = (2*DIF_W)'(diff_ff) * (2*DIF_W)'(diff_ff);
   assign in_band = BND_W'(sq_ff) <= bound_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_idx_ff <= '0;
         kept_ff     <= '0;
      end else if (cmd.bound_mul) begin
         pass_idx_ff <= '0;
         kept_ff     <= '0;
      end else if (cmd.test) begin
         pass_idx_ff <= pass_idx_ff + 1'b1;
         if (in_band) begin
            kept_ff <= kept_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bound_mul) begin
         nq_ff       <= nq_in;
         ss_ff       <= ss_in;
         kept_sum_ff <= '0;
      end else if (cmd.test && in_band) begin
         kept_sum_ff <= kept_sum_ff + SUM_W'(rd_data_ff);
      end
      if (cmd.bound_sub) begin
         bound_ff <= BND_W'({spread, 3'b000}) + BND_W'(spread);
      end
      if (cmd.diff) begin
         diff_ff <= diff_in;
      end
      if (cmd.square) begin
         sq_ff <= diff_sq[SQ_W-1:0];
      end
   end

   // Average with round half up, then scale and offset.
   logic [NUM_W-1:0]        numer;
   logic [NUM_W-1:0]        quot;
   logic                    div_done;
   logic [AVG_W-1:0]        avg;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [PROD_W:0]         prod_round;
   logic [SCL_W-1:0]        scl;
   logic signed [VAL_W-1:0] val_ff, val_in;

   assign numer = {kept_sum_ff, {FRAC_BITS{1'b0}}} + NUM_W'(kept_ff >> 1);

   scsa_div #(
      .NUM_W (NUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (numer),
      .denom (kept_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign avg        = (kept_ff == '0) ? '0 : quot[AVG_W-1:0];
   assign prod_in    = PROD_W'(avg) * PROD_W'(gain_ff);
   assign prod_round = {1'b0, prod_ff} + ROUND_ADD;
   assign scl        = prod_round[PROD_W:SCALE_SHIFT];
   assign val_in     = $signed(VAL_W'(scl)) + VAL_W'(offset_ff);

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         prod_ff <= prod_in;
      end
      if (cmd.offset_add) begin
         val_ff <= val_in;
      end
   end

   // Clamp on the way into the result register.
   logic signed [VAL_W-1:0] low_ext, high_ext;
   logic [VALUE_W-1:0]      value_in;
   logic [CLAMP_W-1:0]      hit_in;
   logic                    rsp_valid_ff;
   logic [VALUE_W-1:0]      rsp_value_ff;
   logic [CNT_W-1:0]        rsp_kept_ff;
   logic [CLAMP_W-1:0]      rsp_hit_ff;
   logic                    rsp_dropped_ff;

   assign low_ext  = VAL_W'(clamp_low_ff);
   assign high_ext = VAL_W'(clamp_high_ff);

   always_comb begin
      value_in = val_ff[VALUE_W-1:0];
      hit_in   = CLAMP_NONE;
      if (val_ff < low_ext) begin
         value_in = clamp_low_ff;
         hit_in   = CLAMP_LOW;
      end else if (val_ff > high_ext) begin
         value_in = clamp_high_ff;
         hit_in   = CLAMP_HIGH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_value_ff   <= value_in;
         rsp_kept_ff    <= kept_ff;
         rsp_hit_ff     <= hit_in;
         rsp_dropped_ff <= overflow_ff;
      end
   end

   assign status.pass_done = pass_idx_ff == count_ff;
   assign status.div_done  = div_done;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_kept_count = rsp_kept_ff;
   assign rsp_clamp_hit  = rsp_hit_ff;
   assign rsp_dropped    = rsp_dropped_ff;

endmodule

// File: rtl/scsa_ctrl.sv
`timescale 1ns / 1ps

module scsa_ctrl import scsa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last,
   input  scsa_status_type status,
   output logic            req_stall,
   output scsa_cmd_type    cmd
);

   scsa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            cmd.take_sample = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_BOUND_MUL;
            end
         end
         ST_BOUND_MUL: begin
            cmd.bound_mul = 1'b1;
            state_in      = ST_BOUND_SUB;
         end
         ST_BOUND_SUB: begin
            cmd.bound_sub = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            if (status.pass_done) begin
               state_in = ST_DIV_START;
            end else begin
               cmd.mem_read = 1'b1;
               state_in     = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_TEST;
         end
         ST_TEST: begin
            cmd.test = 1'b1;
            state_in = ST_READ;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_OFFSET;
         end
         ST_OFFSET: begin
            cmd.offset_add = 1'b1;
            state_in       = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            // Wait here only while an older result is still held downstream.
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/sigma_clipped_sensor_average_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall    req_sample, req_last
// rsp_      out        rsp_valid/rsp_stall    rsp_value, rsp_kept_count, rsp_clamp_hit,
//                                              rsp_dropped
// csr_      in         csr_write_en           csr_index, csr_data
//
// A word without last is taken while req_stall stays low.
// A last word starts the work on the n stored words: each word of the clipping pass goes
// through read, difference, square and compare in turn, and the averaging divider then
// makes one quotient bit per cycle.
// req_stall is high from the last word until the result is in the output register;
// that register lets the next burst load while the previous result is held.
// Reset is synchronous and restores the register defaults and an empty burst.

module sigma_clipped_sensor_average_top import scsa_pkg::*; #(
   parameter int MAX_SAMPLES = 16,
   parameter int ADC_BITS    = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [CSR_INDEX_W-1:0]                csr_index,
   input  logic [CSR_DATA_W-1:0]                 csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ADC_BITS-1:0]                   req_sample,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [VALUE_W-1:0]                    rsp_value,
   output logic [$clog2(MAX_SAMPLES + 1)-1:0]    rsp_kept_count,
   output logic [CLAMP_W-1:0]                    rsp_clamp_hit,
   output logic                                  rsp_dropped
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

   scsa_cmd_type    cmd;
   scsa_status_type status;

   scsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   scsa_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .ADC_BITS    (ADC_BITS),
      .CNT_W       (CNT_W)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_sample     (req_sample),
      .cmd            (cmd),
      .status         (status),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_value      (rsp_value),
      .rsp_kept_count (rsp_kept_count),
      .rsp_clamp_hit  (rsp_clamp_hit),
      .rsp_dropped    (rsp_dropped)
   );

`ifndef SYNTHESIS
   // At least one stored word always lies within three deviations of the mean.
   a_kept_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kept_count != '0 && rsp_kept_count <= CNT_W'(MAX_SAMPLES)))
      else $error("kept count out of range");

   // A new result must never overwrite one that is still waiting downstream.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("result register loaded while occupied");

   // The compare step uses the square made in the cycle before.
   a_test_order: assert property (@(posedge clock) disable iff (reset)
      cmd.test |-> $past(cmd.square))
      else $error("test step without a preceding square");
`endif

endmodule
